@@ rtl/srsp_pkg.sv @@
// ----------------------------------------------------------------------------
// srsp_pkg: shared types, codes and helpers of the slice record stream parser
// Word layouts, result kinds, error codes, sequencer states and float helpers.
// ----------------------------------------------------------------------------
package srsp_pkg;

    localparam int unsigned LABEL_BYTES        = 30;
    localparam int unsigned BOUND_COUNT        = 6;
    localparam int unsigned INDEX_RECORD_BYTES = 24;
    localparam int unsigned TIME_RECORD_BYTES  = 4;
    localparam int unsigned MARKER_BYTES       = 4;

    localparam logic [31:0] MIN_RESET = 32'h7F7F_FFFF;
    localparam logic [31:0] MAX_RESET = 32'hFF7F_FFFF;

    localparam logic [31:0] MAX_RECORD_RESET = 32'd268435456;
    localparam logic [24:0] MAX_VALUES_RESET = 25'd16777216;
    localparam logic [15:0] MAX_FRAMES_RESET = 16'd65535;
    localparam logic [31:0] MAX_TOTAL_RESET  = 32'd268435456;

    // register indexes of the configuration port
    localparam logic [1:0] REG_MAX_RECORD = 2'd0;
    localparam logic [1:0] REG_MAX_VALUES = 2'd1;
    localparam logic [1:0] REG_MAX_FRAMES = 2'd2;
    localparam logic [1:0] REG_MAX_TOTAL  = 2'd3;

    // record ordinals
    localparam logic [2:0] ORD_INDEX  = 3'd3;
    localparam logic [2:0] ORD_TIME   = 3'd4;
    localparam logic [2:0] ORD_VALUES = 3'd5;

    // result kinds
    localparam logic [2:0] KIND_TIME      = 3'd0;
    localparam logic [2:0] KIND_VALUE     = 3'd1;
    localparam logic [2:0] KIND_FRAME_END = 3'd2;
    localparam logic [2:0] KIND_TIME_WARN = 3'd3;
    localparam logic [2:0] KIND_LIMIT     = 3'd4;
    localparam logic [2:0] KIND_ERROR     = 3'd5;
    localparam logic [2:0] KIND_DONE      = 3'd6;

    // error codes
    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_FIRST_MARKER = 4'd1;
    localparam logic [3:0] ERR_TRUNC_MARKER = 4'd2;
    localparam logic [3:0] ERR_TOO_LONG     = 4'd3;
    localparam logic [3:0] ERR_TRUNC_DATA   = 4'd4;
    localparam logic [3:0] ERR_NO_FOOTER    = 4'd5;
    localparam logic [3:0] ERR_FOOTER       = 4'd6;
    localparam logic [3:0] ERR_SIZE         = 4'd7;
    localparam logic [3:0] ERR_DIMENSIONS   = 4'd8;
    localparam logic [3:0] ERR_TIME_NAN     = 4'd9;
    localparam logic [3:0] ERR_VALUE_NAN    = 4'd10;
    localparam logic [3:0] ERR_NO_FRAMES    = 4'd11;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] word;
        logic [15:0] frame_number;
        logic [23:0] value_number;
        logic [31:0] frame_minimum;
        logic [31:0] frame_maximum;
        logic [3:0]  error_code;
        logic        last;
    } out_word_t;

    typedef enum logic [2:0] {
        PH_MARKER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_FOOTER  = 3'b100
    } phase_t;

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_EMIT = 4'b0010,
        C_DIM  = 4'b0100,
        C_DIV  = 4'b1000
    } ctl_t;

    function automatic logic [31:0] swap32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic is_finite(input logic [31:0] w);
        return w[30:23] != 8'hFF;
    endfunction

    // a < b on finite single bits; the two zeros compare equal
    function automatic logic fp_less(input logic [31:0] a, input logic [31:0] b);
        logic lt;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
            lt = 1'b0;
        else if (a[31] != b[31])
            lt = a[31];
        else if (!a[31])
            lt = a[30:0] < b[30:0];
        else
            lt = a[30:0] > b[30:0];
        return lt;
    endfunction

    function automatic out_word_t make_word(input logic [2:0] kind, input logic [31:0] word,
                                            input logic [15:0] fnum, input logic [23:0] vnum,
                                            input logic [31:0] mn, input logic [31:0] mx,
                                            input logic [3:0] err);
        out_word_t r;
        r.kind          = kind;
        r.word          = word;
        r.frame_number  = fnum;
        r.value_number  = vnum;
        r.frame_minimum = mn;
        r.frame_maximum = mx;
        r.error_code    = err;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/srsp_div.sv @@
// ----------------------------------------------------------------------------
// srsp_div: iterative unsigned divider
// Restoring division of a 32-bit dividend by a 25-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module srsp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [24:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import srsp_pkg::*;

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [24:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [24:0] dvs_reg, dvs_next;
    logic [25:0] rem_sh;
    logic [25:0] trial;

    assign rem_sh   = {rem_reg, quo_reg[31]};
    assign trial    = rem_sh - {1'b0, dvs_reg};
    // the last quotient bit is formed in the done cycle itself
    assign quotient = {quo_reg[30:0], !trial[25]};
    assign done     = busy_reg && (cnt_reg == 5'd31);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = 25'd0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (!trial[25])
            begin
                rem_next = trial[24:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[24:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

@@ rtl/slice_record_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// slice_record_stream_parser_unit: record parser for slice data files
// Parses length-framed records byte by byte and streams times and values.
// ----------------------------------------------------------------------------
// Takes one file byte per input word; each byte yields at most two result
// words, and the input stalls while results are delivered. After the bounds
// record's footer the block stalls its input while it forms the slice
// dimensions one axis at a time through one 25x25 multiplier and then the
// frame limit in a bit-serial divider; when both are done it
// resumes. Values stream out before their record footer is checked: discard
// the frame's values if an error word follows. After an error, done or
// limit stop, every byte is taken and dropped until reset.
module slice_record_stream_parser_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  srsp_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output srsp_pkg::out_word_t  out_data,
    input  logic                 cfg_write_en,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import srsp_pkg::*;

    // configuration
    logic [31:0] mrb_reg;
    logic [24:0] mvpf_reg;
    logic [15:0] mf_reg;
    logic [31:0] mtv_reg;

    // sequencer and parser state
    ctl_t        ctl_reg, ctl_next;
    phase_t      phase_reg, phase_next;
    logic [2:0]  ord_reg, ord_next;
    logic [31:0] bcnt_reg, bcnt_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] rlen_reg, rlen_next;
    logic        le_reg, le_next;
    logic [31:0] bounds_reg [BOUND_COUNT];
    logic [31:0] bounds_next [BOUND_COUNT];
    logic [24:0] vcount_reg, vcount_next;
    logic [15:0] flimit_reg, flimit_next;
    logic [15:0] fcnt_reg, fcnt_next;
    logic [31:0] min_reg, min_next;
    logic [31:0] max_reg, max_next;
    logic [31:0] prev_reg, prev_next;
    logic [31:0] ctime_reg, ctime_next;
    logic        halted_reg, halted_next;
    logic [3:0]  perr_reg, perr_next;

    // dimension sequencer
    logic [1:0]  dim_reg, dim_next;
    logic [24:0] prod_reg, prod_next;

    // result buffer
    out_word_t   q0_reg, q0_next;
    out_word_t   q1_reg, q1_next;
    logic        two_reg, two_next;
    logic        head_reg, head_next;

    // divider
    logic        div_start;
    logic        div_done;
    logic [31:0] div_q;

    logic        in_accept;
    logic        out_accept;

    // per-byte working values
    logic [31:0] sh;
    logic [31:0] bc1;
    logic [31:0] wrd;
    logic [31:0] rl;
    logic [31:0] exp_len;
    logic [29:0] pos;
    logic        nle;
    logic        bad;
    logic [33:0] dval [3];
    logic [33:0] dsel;
    logic [49:0] prod;
    out_word_t   r0, r1;
    logic [1:0]  nres;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign in_stall   = (ctl_reg != C_IDLE);
    assign out_valid  = (ctl_reg == C_EMIT);
    assign out_data   = head_reg ? q1_reg : q0_reg;

    srsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mtv_reg),
        .divisor  (vcount_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // extent of each axis: hi - lo + 1, no overflow
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            dval[i] = {{2{bounds_reg[2*i+1][31]}}, bounds_reg[2*i+1]}
                    - {{2{bounds_reg[2*i][31]}}, bounds_reg[2*i]} + 34'd1;
    end

    always_comb
    begin
        unique case (dim_reg)
            2'd0:    dsel = dval[0];
            2'd1:    dsel = dval[1];
            default: dsel = dval[2];
        endcase
    end

    assign prod = prod_reg * dsel[24:0];

    always_comb
    begin
        if (ord_reg < ORD_INDEX)
            exp_len = 32'(LABEL_BYTES);
        else if (ord_reg == ORD_INDEX)
            exp_len = 32'(INDEX_RECORD_BYTES);
        else if (ord_reg == ORD_TIME)
            exp_len = 32'(TIME_RECORD_BYTES);
        else
            exp_len = {5'd0, vcount_reg, 2'd0};
    end

    always_comb
    begin
        ctl_next    = ctl_reg;
        phase_next  = phase_reg;
        ord_next    = ord_reg;
        bcnt_next   = bcnt_reg;
        shift_next  = shift_reg;
        rlen_next   = rlen_reg;
        le_next     = le_reg;
        bounds_next = bounds_reg;
        vcount_next = vcount_reg;
        flimit_next = flimit_reg;
        fcnt_next   = fcnt_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        prev_next   = prev_reg;
        ctime_next  = ctime_reg;
        halted_next = halted_reg;
        perr_next   = perr_reg;
        dim_next    = dim_reg;
        prod_next   = prod_reg;
        q0_next     = q0_reg;
        q1_next     = q1_reg;
        two_next    = two_reg;
        head_next   = head_reg;
        div_start   = 1'b0;
        r0          = make_word(KIND_DONE, 32'd0, fcnt_reg, 24'd0, 32'd0, 32'd0, ERR_NONE);
        r1          = r0;
        nres        = 2'd0;
        bad         = 1'b0;
        nle         = le_reg;

        sh  = {shift_reg[23:0], in_data.data_byte};
        bc1 = bcnt_reg + 32'd1;
        wrd = le_reg ? swap32(sh) : sh;
        pos = bc1[31:2] - 30'd1;
        rl  = 32'd0;

        unique case (ctl_reg)
            C_IDLE:
            begin
                if (in_accept && !halted_reg)
                begin
                    if (in_data.end_of_stream)
                    begin
                        halted_next = 1'b1;
                        nres        = 2'd1;
                        if (phase_reg == PH_MARKER && ord_reg == ORD_TIME
                            && bcnt_reg == 32'd0)
                        begin
                            if (fcnt_reg == 16'd0)
                                r0 = make_word(KIND_ERROR, 32'd0, fcnt_reg, 24'd0, 32'd0,
                                               32'd0, ERR_NO_FRAMES);
                        end
                        else if (phase_reg == PH_MARKER)
                            r0 = make_word(KIND_ERROR, 32'd0, fcnt_reg, 24'd0, 32'd0, 32'd0,
                                           ERR_TRUNC_MARKER);
                        else if (phase_reg == PH_PAYLOAD)
                            r0 = make_word(KIND_ERROR, 32'd0, fcnt_reg, 24'd0, 32'd0, 32'd0,
                                           ERR_TRUNC_DATA);
                        else
                            r0 = make_word(KIND_ERROR, 32'd0, fcnt_reg, 24'd0, 32'd0, 32'd0,
                                           ERR_NO_FOOTER);
                    end
                    else if (phase_reg == PH_MARKER)
                    begin
                        if (ord_reg == ORD_TIME && bcnt_reg == 32'd0
                            && fcnt_reg >= flimit_reg)
                        begin
                            // frame limit reached: drop the byte and stop
                            halted_next = 1'b1;
                            nres        = 2'd2;
                            r0 = make_word(KIND_LIMIT, 32'd0, fcnt_reg, 24'd0, 32'd0, 32'd0,
                                           ERR_NONE);
                            if (fcnt_reg == 16'd0)
                                r1 = make_word(KIND_ERROR, 32'd0, fcnt_reg, 24'd0, 32'd0,
                                               32'd0, ERR_NO_FRAMES);
                        end
                        else
                        begin
                            shift_next = sh;
                            bcnt_next  = bc1;
                            if (bc1 == 32'(MARKER_BYTES))
                            begin
                                if (ord_reg == 3'd0)
                                begin
                                    // byte order from the first marker
                                    if (swap32(sh) == 32'(LABEL_BYTES))
                                        nle = 1'b1;
                                    else if (sh == 32'(LABEL_BYTES))
                                        nle = 1'b0;
                                    else
                                        bad = 1'b1;
                                    le_next = nle;
                                end
                                rl = nle ? swap32(sh) : sh;
                                if (bad)
                                begin
                                    halted_next = 1'b1;
                                    nres        = 2'd1;
                                    r0 = make_word(KIND_ERROR, 32'd0, fcnt_reg, 24'd0, 32'd0,
                                                   32'd0, ERR_FIRST_MARKER);
                                end
                                else if (rl > mrb_reg)
                                begin
                                    halted_next = 1'b1;
                                    nres        = 2'd1;
                                    r0 = make_word(KIND_ERROR, 32'd0, fcnt_reg, 24'd0, 32'd0,
                                                   32'd0, ERR_TOO_LONG);
                                end
                                else
                                begin
                                    rlen_next  = rl;
                                    perr_next  = (rl != exp_len) ? ERR_SIZE : ERR_NONE;
                                    bcnt_next  = 32'd0;
                                    shift_next = 32'd0;
                                    phase_next = (rl == 32'd0) ? PH_FOOTER : PH_PAYLOAD;
                                end
                            end
                        end
                    end
                    else if (phase_reg == PH_PAYLOAD)
                    begin
                        shift_next = sh;
                        bcnt_next  = bc1;
                        if (bc1[1:0] == 2'd0 && perr_reg == ERR_NONE)
                        begin
                            if (ord_reg == ORD_INDEX)
                            begin
                                if (pos < 30'(BOUND_COUNT))
                                    bounds_next[pos[2:0]] = wrd;
                            end
                            else if (ord_reg == ORD_TIME)
                                ctime_next = wrd;
                            else if (ord_reg == ORD_VALUES)
                            begin
                                if (!is_finite(wrd))
                                    perr_next = ERR_VALUE_NAN;
                                else
                                begin
                                    if (fp_less(wrd, min_reg))
                                        min_next = wrd;
                                    if (fp_less(max_reg, wrd))
                                        max_next = wrd;
                                    nres = 2'd1;
                                    r0 = make_word(KIND_VALUE, wrd, fcnt_reg, pos[23:0],
                                                   32'd0, 32'd0, ERR_NONE);
                                end
                            end
                        end
                        if (bc1 >= rlen_reg)
                        begin
                            phase_next = PH_FOOTER;
                            bcnt_next  = 32'd0;
                            shift_next = 32'd0;
                        end
                    end
                    else
                    begin
                        shift_next = sh;
                        bcnt_next  = bc1;
                        if (bc1 == 32'(MARKER_BYTES))
                        begin
                            if (wrd != rlen_reg)
                            begin
                                halted_next = 1'b1;
                                nres        = 2'd1;
                                r0 = make_word(KIND_ERROR, 32'd0, fcnt_reg, 24'd0, 32'd0,
                                               32'd0, ERR_FOOTER);
                            end
                            else if (perr_reg != ERR_NONE)
                            begin
                                halted_next = 1'b1;
                                nres        = 2'd1;
                                r0 = make_word(KIND_ERROR, 32'd0, fcnt_reg, 24'd0, 32'd0,
                                               32'd0, perr_reg);
                            end
                            else
                            begin
                                phase_next = PH_MARKER;
                                bcnt_next  = 32'd0;
                                if (ord_reg < ORD_INDEX)
                                    ord_next = ord_reg + 3'd1;
                                else if (ord_reg == ORD_INDEX)
                                begin
                                    // hand over to the dimension sequencer
                                    ctl_next  = C_DIM;
                                    dim_next  = 2'd0;
                                    prod_next = 25'd1;
                                end
                                else if (ord_reg == ORD_TIME)
                                begin
                                    nres = 2'd1;
                                    if (!is_finite(ctime_reg))
                                    begin
                                        halted_next = 1'b1;
                                        r0 = make_word(KIND_ERROR, 32'd0, fcnt_reg, 24'd0,
                                                       32'd0, 32'd0, ERR_TIME_NAN);
                                    end
                                    else
                                    begin
                                        ord_next = ORD_VALUES;
                                        r0 = make_word(KIND_TIME, ctime_reg, fcnt_reg, 24'd0,
                                                       32'd0, 32'd0, ERR_NONE);
                                    end
                                end
                                else
                                begin
                                    r0 = make_word(KIND_FRAME_END, ctime_reg, fcnt_reg,
                                                   24'd0, min_reg, max_reg, ERR_NONE);
                                    nres = 2'd1;
                                    if (fcnt_reg != 16'd0 && fp_less(ctime_reg, prev_reg))
                                    begin
                                        r1   = r0;
                                        r0   = make_word(KIND_TIME_WARN, ctime_reg, fcnt_reg,
                                                         24'd0, 32'd0, 32'd0, ERR_NONE);
                                        nres = 2'd2;
                                    end
                                    fcnt_next = fcnt_reg + 16'd1;
                                    prev_next = ctime_reg;
                                    min_next  = MIN_RESET;
                                    max_next  = MAX_RESET;
                                    ord_next  = ORD_TIME;
                                end
                            end
                        end
                    end

                    // load the result buffer
                    if (nres != 2'd0)
                    begin
                        if (nres == 2'd1)
                            r0.last = 1'b1;
                        else
                            r1.last = 1'b1;
                        q0_next   = r0;
                        q1_next   = r1;
                        two_next  = (nres == 2'd2);
                        head_next = 1'b0;
                        ctl_next  = C_EMIT;
                    end
                end
            end

            C_EMIT:
            begin
                if (out_accept)
                begin
                    if (two_reg && !head_reg)
                        head_next = 1'b1;
                    else
                        ctl_next = C_IDLE;
                end
            end

            C_DIM:
            begin
                // one axis a cycle through the shared multiplier
                if (dsel[33] || dsel == 34'd0 || dsel > {9'd0, mvpf_reg}
                    || prod > {25'd0, mvpf_reg})
                begin
                    halted_next = 1'b1;
                    q0_next     = make_word(KIND_ERROR, 32'd0, fcnt_reg, 24'd0, 32'd0,
                                            32'd0, ERR_DIMENSIONS);
                    q0_next.last = 1'b1;
                    two_next    = 1'b0;
                    head_next   = 1'b0;
                    ctl_next    = C_EMIT;
                end
                else
                begin
                    prod_next = prod[24:0];
                    dim_next  = dim_reg + 2'd1;
                    if (dim_reg == 2'd2)
                    begin
                        vcount_next = prod[24:0];
                        ctl_next    = C_DIV;
                    end
                end
            end

            C_DIV:
            begin
                if (dim_reg == 2'd3)
                begin
                    // launch the divider once
                    div_start = 1'b1;
                    dim_next  = 2'd0;
                end
                else if (div_done)
                begin
                    flimit_next = (div_q < {16'd0, mf_reg}) ? div_q[15:0] : mf_reg;
                    ord_next    = ORD_TIME;
                    ctl_next    = C_IDLE;
                end
            end

            default:
            begin
                ctl_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mrb_reg    <= MAX_RECORD_RESET;
            mvpf_reg   <= MAX_VALUES_RESET;
            mf_reg     <= MAX_FRAMES_RESET;
            mtv_reg    <= MAX_TOTAL_RESET;
            ctl_reg    <= C_IDLE;
            phase_reg  <= PH_MARKER;
            ord_reg    <= 3'd0;
            bcnt_reg   <= 32'd0;
            shift_reg  <= 32'd0;
            rlen_reg   <= 32'd0;
            le_reg     <= 1'b0;
            for (int i = 0; i < BOUND_COUNT; i++)
                bounds_reg[i] <= 32'd0;
            vcount_reg <= 25'd0;
            flimit_reg <= 16'd0;
            fcnt_reg   <= 16'd0;
            min_reg    <= MIN_RESET;
            max_reg    <= MAX_RESET;
            prev_reg   <= 32'd0;
            ctime_reg  <= 32'd0;
            halted_reg <= 1'b0;
            perr_reg   <= ERR_NONE;
            dim_reg    <= 2'd0;
            two_reg    <= 1'b0;
            head_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    REG_MAX_RECORD: mrb_reg  <= cfg_data;
                    REG_MAX_VALUES: mvpf_reg <= cfg_data[24:0];
                    REG_MAX_FRAMES: mf_reg   <= cfg_data[15:0];
                    REG_MAX_TOTAL:  mtv_reg  <= cfg_data;
                    default:        mtv_reg  <= mtv_reg;
                endcase
            end
            ctl_reg    <= ctl_next;
            phase_reg  <= phase_next;
            ord_reg    <= ord_next;
            bcnt_reg   <= bcnt_next;
            shift_reg  <= shift_next;
            rlen_reg   <= rlen_next;
            le_reg     <= le_next;
            bounds_reg <= bounds_next;
            vcount_reg <= vcount_next;
            flimit_reg <= flimit_next;
            fcnt_reg   <= fcnt_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            prev_reg   <= prev_next;
            ctime_reg  <= ctime_next;
            halted_reg <= halted_next;
            perr_reg   <= perr_next;
            dim_reg    <= dim_next;
            two_reg    <= two_next;
            head_reg   <= head_next;
        end
    end

    // payload of the result buffer and the product
    always_ff @(posedge clk)
    begin
        q0_reg   <= q0_next;
        q1_reg   <= q1_next;
        prod_reg <= prod_next;
    end

endmodule

@@ tb/slice_record_stream_parser_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slice_record_stream_parser_unit_tb: self-checking bench for the record parser
// Streams one slice file with random content (byte order, bounds, times,
// values) and a random way of ending it: clean end, frame limit or one of the
// fault cases. A predictor computes every result word. The monitor checks the
// results in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module slice_record_stream_parser_unit_tb;

    import srsp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 60;   // covers the multiplier and divider pass

    // ways the file is closed
    typedef enum int {
        END_DONE, END_LIMIT, END_VALUE_NAN, END_TIME_NAN, END_FOOTER, END_TRUNC_DATA,
        END_TRUNC_FOOTER, END_TRUNC_MARKER, END_SIZE, END_TOO_LONG, END_FIRST_MARKER,
        END_DIMS, END_NO_FRAMES
    } file_end_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_word_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_word_t   out_data;
    logic        cfg_write_en = 1'b0;
    logic [1:0]  cfg_index = REG_MAX_RECORD;
    logic [31:0] cfg_data = '0;

    slice_record_stream_parser_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // bytes waiting to be sent and result words still owed by the block
    in_word_t  file_bytes[$];
    out_word_t owed_words[$];
    out_word_t step_words[$];

    int  mismatches = 0;
    int  cycles = 0;
    bit  file_le;

    // register shadows
    logic [31:0] lim_record = MAX_RECORD_RESET;
    logic [24:0] lim_values = MAX_VALUES_RESET;
    logic [15:0] lim_frames = MAX_FRAMES_RESET;
    logic [31:0] lim_total  = MAX_TOTAL_RESET;

    // parser state as the predictor sees it
    phase_t      p_phase = PH_MARKER;
    logic [2:0]  p_ord = '0;
    logic [31:0] p_count = '0;
    logic [31:0] p_shift = '0;
    logic [31:0] p_len = '0;
    logic        p_le = 1'b0;
    logic [31:0] p_bounds [0:5];
    logic [31:0] p_vcount = '0;
    logic [31:0] p_flimit = '0;
    logic [15:0] p_frames = '0;
    logic [31:0] p_min = MIN_RESET;
    logic [31:0] p_max = MAX_RESET;
    logic [31:0] p_prev_time = '0;
    logic [31:0] p_time = '0;
    logic        p_halted = 1'b0;
    logic [3:0]  p_fault = ERR_NONE;

    initial
    begin
        foreach (p_bounds[i]) p_bounds[i] = '0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // ordering key of finite single bits; both zeros map to the same key
    function automatic longint order_key(input logic [31:0] w);
        return w[31] ? -longint'(w[30:0]) : longint'(w[30:0]);
    endfunction

    function automatic logic [31:0] in_file_order(input logic [31:0] w);
        return p_le ? {<<8{w}} : w;
    endfunction

    task automatic add_result(input logic [2:0] kind, input logic [31:0] w,
                              input logic [23:0] vnum, input logic [31:0] mn,
                              input logic [31:0] mx, input logic [3:0] code);
        out_word_t r;
        r.kind = kind;
        r.word = w;
        r.frame_number = p_frames;
        r.value_number = vnum;
        r.frame_minimum = mn;
        r.frame_maximum = mx;
        r.error_code = code;
        r.last = 1'b0;
        step_words.push_back(r);
    endtask

    task automatic abort_file(input logic [3:0] code);
        p_halted = 1'b1;
        add_result(KIND_ERROR, '0, '0, '0, '0, code);
    endtask

    task automatic close_file();
        p_halted = 1'b1;
        if (p_frames == 0)
            add_result(KIND_ERROR, '0, '0, '0, '0, ERR_NO_FRAMES);
        else
            add_result(KIND_DONE, '0, '0, '0, '0, ERR_NONE);
    endtask

    function automatic logic [31:0] record_size_due();
        if (p_ord < ORD_INDEX) return LABEL_BYTES;
        if (p_ord == ORD_INDEX) return INDEX_RECORD_BYTES;
        if (p_ord == ORD_TIME) return TIME_RECORD_BYTES;
        return p_vcount * 4;
    endfunction

    // slice size from the bounds, then the frame limit; 0 on bad dimensions
    function automatic bit size_slice();
        longint d;
        longint prod;
        prod = 1;
        for (int i = 0; i < 3; i++)
        begin
            d = longint'($signed(p_bounds[2*i+1])) - longint'($signed(p_bounds[2*i])) + 1;
            if (d <= 0 || d > longint'(lim_values)) return 1'b0;
            prod = prod * d;
            if (prod > longint'(lim_values)) return 1'b0;
        end
        p_vcount = prod[31:0];
        p_flimit = lim_total / p_vcount;
        if ({16'd0, lim_frames} < p_flimit) p_flimit = {16'd0, lim_frames};
        return 1'b1;
    endfunction

    task automatic take_payload_word(input logic [31:0] w, input logic [31:0] pos);
        if (p_fault == ERR_NONE)
        begin
            if (p_ord == ORD_INDEX)
            begin
                if (pos < BOUND_COUNT) p_bounds[pos] = w;
            end
            else if (p_ord == ORD_TIME)
                p_time = w;
            else if (p_ord == ORD_VALUES)
            begin
                if (w[30:23] == 8'hFF)
                    p_fault = ERR_VALUE_NAN;
                else
                begin
                    if (order_key(w) < order_key(p_min)) p_min = w;
                    if (order_key(p_max) < order_key(w)) p_max = w;
                    add_result(KIND_VALUE, w, pos[23:0], '0, '0, ERR_NONE);
                end
            end
        end
    endtask

    task automatic close_record();
        if (in_file_order(p_shift) != p_len)
            abort_file(ERR_FOOTER);
        else if (p_fault != ERR_NONE)
            abort_file(p_fault);
        else
        begin
            p_phase = PH_MARKER;
            p_count = 0;
            if (p_ord < ORD_INDEX)
                p_ord = p_ord + 1;
            else if (p_ord == ORD_INDEX)
            begin
                if (!size_slice()) abort_file(ERR_DIMENSIONS);
                else p_ord = ORD_TIME;
            end
            else if (p_ord == ORD_TIME)
            begin
                if (p_time[30:23] == 8'hFF)
                    abort_file(ERR_TIME_NAN);
                else
                begin
                    p_ord = ORD_VALUES;
                    add_result(KIND_TIME, p_time, '0, '0, '0, ERR_NONE);
                end
            end
            else
            begin
                if (p_frames > 0 && order_key(p_time) < order_key(p_prev_time))
                    add_result(KIND_TIME_WARN, p_time, '0, '0, '0, ERR_NONE);
                add_result(KIND_FRAME_END, p_time, '0, p_min, p_max, ERR_NONE);
                p_frames = p_frames + 1;
                p_prev_time = p_time;
                p_min = MIN_RESET;
                p_max = MAX_RESET;
                p_ord = ORD_TIME;
            end
        end
    endtask

    // advance the predictor by one accepted byte and queue what it owes
    task automatic predict_byte(input in_word_t it);
        step_words = {};
        if (!p_halted)
        begin
            if (it.end_of_stream)
            begin
                if (p_phase == PH_MARKER)
                begin
                    if (p_ord == ORD_TIME && p_count == 0) close_file();
                    else abort_file(ERR_TRUNC_MARKER);
                end
                else if (p_phase == PH_PAYLOAD)
                    abort_file(ERR_TRUNC_DATA);
                else
                    abort_file(ERR_NO_FOOTER);
            end
            else if (p_phase == PH_MARKER)
            begin
                if (p_ord == ORD_TIME && p_count == 0 && {16'd0, p_frames} >= p_flimit)
                begin
                    p_halted = 1'b1;
                    add_result(KIND_LIMIT, '0, '0, '0, '0, ERR_NONE);
                    close_file();
                end
                else
                begin
                    p_shift = {p_shift[23:0], it.data_byte};
                    p_count = p_count + 1;
                    if (p_count == MARKER_BYTES)
                    begin
                        // the first marker fixes the byte order
                        if (p_ord == 0)
                        begin
                            if ({<<8{p_shift}} == LABEL_BYTES) p_le = 1'b1;
                            else if (p_shift == LABEL_BYTES) p_le = 1'b0;
                            else abort_file(ERR_FIRST_MARKER);
                        end
                        if (!p_halted)
                        begin
                            p_len = in_file_order(p_shift);
                            if (p_len > lim_record)
                                abort_file(ERR_TOO_LONG);
                            else
                            begin
                                p_fault = (p_len != record_size_due()) ? ERR_SIZE : ERR_NONE;
                                p_count = 0;
                                p_shift = 0;
                                p_phase = (p_len == 0) ? PH_FOOTER : PH_PAYLOAD;
                            end
                        end
                    end
                end
            end
            else if (p_phase == PH_PAYLOAD)
            begin
                p_shift = {p_shift[23:0], it.data_byte};
                p_count = p_count + 1;
                if (p_count[1:0] == 2'd0)
                    take_payload_word(in_file_order(p_shift), (p_count >> 2) - 1);
                if (p_count >= p_len)
                begin
                    p_phase = PH_FOOTER;
                    p_count = 0;
                    p_shift = 0;
                end
            end
            else
            begin
                p_shift = {p_shift[23:0], it.data_byte};
                p_count = p_count + 1;
                if (p_count == MARKER_BYTES) close_record();
            end
        end
        if (step_words.size() > 0) step_words[$].last = 1'b1;
        foreach (step_words[i]) owed_words.push_back(step_words[i]);
    endtask

    // ------------------------------------------------------------------
    // Driver: send queued bytes, idling a random number of cycles before each
    // ------------------------------------------------------------------
    int  send_gap = 0;
    bit  send_calm = 1'b0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_byte(in_data);
            // hold a stalled word; otherwise idle or advance
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (file_bytes.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= file_bytes.pop_front();
                    if ($urandom_range(0, 60) == 0) send_calm = ~send_calm;
                    send_gap <= send_calm ? 0 : $urandom_range(0, 18);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result word against the oldest owed one
    // ------------------------------------------------------------------
    int  recv_hold = 0;
    bit  recv_calm = 1'b0;

    always @(posedge clk)
    begin
        out_word_t due;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_words.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, out_data);
                    mismatches++;
                end
                else
                begin
                    due = owed_words.pop_front();
                    if (out_data.kind !== due.kind || out_data.word !== due.word
                        || out_data.frame_number !== due.frame_number
                        || out_data.value_number !== due.value_number
                        || out_data.frame_minimum !== due.frame_minimum
                        || out_data.frame_maximum !== due.frame_maximum
                        || out_data.error_code !== due.error_code
                        || out_data.last !== due.last)
                    begin
                        $display("%0t: mismatch expected kind=%0d word=%h frame=%0d value=%0d min=%h max=%h err=%0d last=%b",
                                 $time, due.kind, due.word, due.frame_number,
                                 due.value_number, due.frame_minimum, due.frame_maximum,
                                 due.error_code, due.last);
                        $display("%0t:          actual   kind=%0d word=%h frame=%0d value=%0d min=%h max=%h err=%0d last=%b",
                                 $time, out_data.kind, out_data.word, out_data.frame_number,
                                 out_data.value_number, out_data.frame_minimum,
                                 out_data.frame_maximum, out_data.error_code, out_data.last);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 50) == 0) recv_calm = ~recv_calm;
                recv_hold = recv_calm ? 0 : $urandom_range(0, 18);
            end
            if (recv_hold > 0)
            begin
                out_stall <= 1'b1;
                recv_hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("slice_record_stream_parser_unit_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // File builder
    // ------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] b);
        file_bytes.push_back('{data_byte: b, end_of_stream: 1'b0});
    endtask

    task automatic put_end();
        file_bytes.push_back('{data_byte: 8'($urandom), end_of_stream: 1'b1});
    endtask

    task automatic put_word(input logic [31:0] w);
        if (file_le)
            for (int i = 0; i < 4; i++) put_byte(w[8*i +: 8]);
        else
            for (int i = 3; i >= 0; i--) put_byte(w[8*i +: 8]);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_MAX_RECORD: lim_record = value;
            REG_MAX_VALUES: lim_values = value[24:0];
            REG_MAX_FRAMES: lim_frames = value[15:0];
            default:        lim_total = value;
        endcase
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // hold until every byte is in and every result is out, then let it drain
    task automatic drain();
        do @(posedge clk);
        while (file_bytes.size() > 0 || in_valid || owed_words.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] finite_single();
        return {1'($urandom), 8'($urandom_range(0, 254)), 23'($urandom)};
    endfunction

    // value list walked by the first frames: zeros, extremes, tiny and plain
    logic [31:0] corner_values [0:9] = '{32'h0000_0000, 32'h8000_0000, 32'h7F7F_FFFF,
        32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0001, 32'h3F80_0000, 32'hBF80_0000,
        32'h007F_FFFF, 32'h4049_0FDB};

    initial
    begin
        file_end_t   ending;
        int          dim [0:2];
        int          vcount;
        int          frames;
        int          corner;
        int          bad_pos;
        logic [31:0] lo;
        logic [31:0] t;
        logic [31:0] len;
        logic [31:0] v;
        logic [31:0] record_need;

        ending = file_end_t'($urandom_range(0, 12));
        file_le = $urandom_range(0, 1);
        dim[0] = $urandom_range(1, 3);
        dim[1] = $urandom_range(1, 2);
        dim[2] = $urandom_range(1, 2);
        vcount = dim[0] * dim[1] * dim[2];
        frames = 1750 / (20 + 4 * vcount);
        record_need = (4 * vcount > LABEL_BYTES) ? 4 * vcount : LABEL_BYTES;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // initial register setting; the frame limit is fixed by these
        write_reg(REG_MAX_RECORD, $urandom_range(0, 1) ? 32'hFFFF_FFFF : record_need);
        write_reg(REG_MAX_VALUES, $urandom_range(0, 1) ? 32'd16777216 : vcount);
        if (ending == END_LIMIT)
        begin
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_MAX_FRAMES, frames);
                write_reg(REG_MAX_TOTAL, 32'hFFFF_FFFF);
            end
            else
            begin
                write_reg(REG_MAX_FRAMES, 32'd65535);
                write_reg(REG_MAX_TOTAL, frames * vcount + $urandom_range(0, vcount - 1));
            end
        end
        else
        begin
            write_reg(REG_MAX_FRAMES, 32'd65535);
            write_reg(REG_MAX_TOTAL, $urandom_range(0, 1) ? 32'hFFFF_FFFF : MAX_TOTAL_RESET);
        end

        // three label records; a bad first marker ends the file at once
        if (ending == END_FIRST_MARKER)
            put_word(LABEL_BYTES + $urandom_range(1, 200));
        else
            put_word(LABEL_BYTES);
        for (int i = 0; i < LABEL_BYTES; i++) put_byte(8'($urandom));
        put_word(LABEL_BYTES);
        for (int r = 0; r < 2; r++)
        begin
            put_word(LABEL_BYTES);
            for (int i = 0; i < LABEL_BYTES; i++) put_byte(8'($urandom));
            put_word(LABEL_BYTES);
        end
        drain();
        write_reg(REG_MAX_RECORD, $urandom_range(0, 1) ? 32'hFFFF_FFFF : record_need);

        // bounds record; the low bound sits at an extreme now and then
        put_word(INDEX_RECORD_BYTES);
        for (int i = 0; i < 3; i++)
        begin
            case ($urandom_range(0, 2))
                0: lo = 32'h8000_0000;
                1: lo = 32'h7FFF_FFFF - dim[i] + 1;
                default: lo = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
            endcase
            put_word(lo);
            if (ending == END_DIMS && i == 2) put_word(lo - 1);
            else put_word(lo + dim[i] - 1);
        end
        put_word(INDEX_RECORD_BYTES);
        if (ending == END_NO_FRAMES) put_end();
        drain();
        write_reg(REG_MAX_VALUES, $urandom_range(0, 1) ? 32'd1 : 32'd16777216);

        corner = 0;
        t = 32'h3C00_0000;
        for (int f = 0; f < frames; f++)
        begin
            // reprogram now and then; limits are latched, so only size matters
            if (f % 25 == 24)
            begin
                drain();
                write_reg(REG_MAX_FRAMES, $urandom_range(0, 1) ? 32'd0 : 32'd65535);
                write_reg(REG_MAX_TOTAL, $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF);
                write_reg(REG_MAX_RECORD, $urandom_range(0, 1) ? 32'hFFFF_FFFF : record_need);
            end

            // time: mostly rising, sometimes stepping back, a sign flip rarely
            if (f == 1 || $urandom_range(0, 7) == 0) t = t - $urandom_range(1, 1 << 20);
            else t = t + $urandom_range(1, 1 << 18);
            v = ($urandom_range(0, 40) == 0) ? {~t[31], t[30:0]} : t;
            if (ending == END_TIME_NAN && f == frames - 1)
                v = {1'($urandom), 8'hFF, 23'($urandom_range(0, 1) ? $urandom : 0)};
            put_word(TIME_RECORD_BYTES);
            put_word(v);
            put_word(TIME_RECORD_BYTES);

            if (ending == END_TOO_LONG && f == frames - 1)
            begin
                drain();
                write_reg(REG_MAX_RECORD, $urandom_range(0, 1) ? 32'd0 : 4 * vcount - 1);
            end

            len = 4 * vcount;
            if (ending == END_SIZE && f == frames - 1) len = len + 4;
            bad_pos = (ending == END_VALUE_NAN && f == frames - 1)
                      ? $urandom_range(0, vcount - 1) : -1;
            put_word(len);
            for (int i = 0; i < len / 4; i++)
            begin
                if (corner < 10) v = corner_values[corner++];
                else v = finite_single();
                if (i == bad_pos) v = {1'($urandom), 8'hFF, 23'($urandom)};
                if (ending == END_TRUNC_DATA && f == frames - 1 && i == len / 4 - 1)
                begin
                    put_byte(v[7:0]);
                    put_end();
                end
                else
                    put_word(v);
            end
            if (ending == END_TRUNC_FOOTER && f == frames - 1)
            begin
                put_byte(8'($urandom));
                put_end();
            end
            else if (ending == END_FOOTER && f == frames - 1)
                put_word(len ^ (32'd1 << $urandom_range(0, 31)));
            else
                put_word(len);
        end

        // close the file; anything after the stop is dropped by the block
        if (ending == END_TRUNC_MARKER)
        begin
            put_byte(8'($urandom));
            put_byte(8'($urandom));
        end
        else if (ending == END_LIMIT)
            put_byte(8'($urandom));
        put_end();
        for (int i = 0; i < 8; i++) put_byte(8'($urandom));

        drain();
        if (mismatches == 0)
            $display("slice_record_stream_parser_unit_tb passed");
        else
            $display("slice_record_stream_parser_unit_tb failed");
        $finish;
    end

endmodule
